[rtl/core/stbs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the sorted table binary search block.
// No dependencies; used by every module in rtl/core.

package stbs_pkg;

    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 10;
    localparam int COUNT_W = 11;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_result;

endpackage

[rtl/core/stbs_table_mem.sv]
`timescale 1ns / 1ps
// Table storage: one write port and one read port, read data registered.
// Depends on stbs_pkg for the entry width.

module stbs_table_mem #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    i_waddr,
    input  logic [stbs_pkg::VALUE_W-1:0]      i_wdata,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    i_raddr,
    output logic [stbs_pkg::VALUE_W-1:0]      o_rdata
);

    logic [stbs_pkg::VALUE_W-1:0] r_mem [TABLE_DEPTH];
    logic [stbs_pkg::VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/stbs_search_ctrl.sv]
`timescale 1ns / 1ps
// Search sequencer: takes items, drives the table ports, narrows the range
// one probe per cycle and holds the result item. Depends on stbs_pkg.

module stbs_search_ctrl #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_cmd,
    input  logic [stbs_pkg::INDEX_W-1:0]         i_index,
    input  logic [stbs_pkg::VALUE_W-1:0]         i_value,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]     i_count,
    output logic                                 o_mem_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]       o_mem_waddr,
    output logic [stbs_pkg::VALUE_W-1:0]         o_mem_wdata,
    output logic [$clog2(TABLE_DEPTH)-1:0]       o_mem_raddr,
    input  logic [stbs_pkg::VALUE_W-1:0]         i_mem_rdata,
    output logic                                 o_valid,
    input  logic                                 i_out_ready,
    output stbs_pkg::t_result                    o_result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic [CW-1:0]                r_low, n_low;
    logic [CW-1:0]                r_hiex, n_hiex;
    logic [AW-1:0]                r_mid, n_mid;
    logic [stbs_pkg::VALUE_W-1:0] r_target, n_target;
    stbs_pkg::t_result            r_res, n_res;
    logic                         r_out_valid, n_out_valid;
    stbs_pkg::t_result            r_out, n_out;

    logic          accept;
    logic          hit;
    logic          less;
    logic [CW-1:0] low_c;
    logic [CW-1:0] hiex_c;
    logic          empty;
    logic [CW-1:0] mid_c;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    assign hit  = (i_mem_rdata == r_target);
    assign less = ($signed(i_mem_rdata) < $signed(r_target));

    // candidate range after this cycle's compare
    always_comb begin
        low_c  = r_low;
        hiex_c = r_hiex;
        if (r_state == S_PROBE) begin
            if (less) begin
                low_c = CW'(r_mid) + CW'(1);
            end else begin
                hiex_c = CW'(r_mid);
            end
        end
    end

    assign empty = (low_c >= hiex_c);
    assign mid_c = low_c + ((hiex_c - CW'(1) - low_c) >> 1);

    assign o_mem_raddr = mid_c[AW-1:0];
    assign o_mem_we    = accept && (i_cmd == stbs_pkg::CMD_WRITE)
                         && (32'(i_index) < 32'(TABLE_DEPTH));
    assign o_mem_waddr = AW'(i_index);
    assign o_mem_wdata = i_value;

    always_comb begin
        n_state     = r_state;
        n_low       = r_low;
        n_hiex      = r_hiex;
        n_mid       = r_mid;
        n_target    = r_target;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_cmd == stbs_pkg::CMD_SEARCH)) begin
                    n_low    = '0;
                    n_hiex   = i_count;
                    n_target = i_value;
                    n_state  = S_START;
                end
            end
            S_START: begin
                if (empty) begin
                    n_res   = '0;
                    n_state = S_DONE;
                end else begin
                    n_mid   = mid_c[AW-1:0];
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (hit) begin
                    n_res.found    = 1'b1;
                    n_res.position = stbs_pkg::POS_W'(r_mid);
                    n_state        = S_DONE;
                end else if (empty) begin
                    n_res   = '0;
                    n_state = S_DONE;
                end else begin
                    n_low  = low_c;
                    n_hiex = hiex_c;
                    n_mid  = mid_c[AW-1:0];
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low    <= n_low;
        r_hiex   <= n_hiex;
        r_mid    <= n_mid;
        r_target <= n_target;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // probe address always lies inside the live range
    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> ((r_low <= CW'(r_mid)) && (CW'(r_mid) < r_hiex)))
        else $error("probe outside search range");

    a_hit_ends_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE && hit) |=> (r_state == S_DONE && r_res.found))
        else $error("matching entry did not end the search");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == stbs_pkg::CMD_SEARCH) |=> !o_ready)
        else $error("new item taken while a search runs");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (r_state == S_IDLE))
        else $error("table written during a search");

endmodule

[rtl/core/sorted_table_binary_search.sv]
`timescale 1ns / 1ps
// Top level of the sorted table binary search block.
// Depends on stbs_pkg, stbs_table_mem and stbs_search_ctrl.

// The block keeps a table of TABLE_DEPTH signed 32-bit entries in one
// synchronous RAM, written one position at a time and expected to be in
// ascending order. An input item with tuser low writes its value at its
// index (an index at or beyond TABLE_DEPTH is dropped) and yields no result.
// An item with tuser high searches the first entry_count entries
// (saturated to TABLE_DEPTH) for its value and yields one result item:
// tuser says whether a match was found and tdata carries its position, or
// zero. A search makes at most $clog2(TABLE_DEPTH) + 1 probes (11 for a
// 1024 entry table) before its result item is offered; no new item is
// taken before then. One probe a cycle is set by the RAM read port: the
// compare of one read narrows the range and issues the next address in the
// same cycle. Only one item is at work at a time; the result register lets
// the next item be taken while a result still waits on the master side. The
// RAM has no reset: search only entries that have been written. Write
// entry_count only while the block is idle.

module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [stbs_pkg::COUNT_W-1:0]      i_cfg_wr_data,   // entry_count
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [stbs_pkg::S_TDATA_W-1:0]    s_axis_tdata,    // index[9:0], value[41:10]
    input  logic                              s_axis_tuser,    // cmd
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [stbs_pkg::M_TDATA_W-1:0]    m_axis_tdata,    // position[9:0]
    output logic                              m_axis_tuser     // found
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [stbs_pkg::COUNT_W-1:0] r_entry_count;
    logic [CW-1:0]                count_sat;

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [stbs_pkg::VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]                mem_raddr;
    logic [stbs_pkg::VALUE_W-1:0] mem_rdata;
    stbs_pkg::t_result            result;

    // hold the count register; the user must change it only between items (unchecked)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_wr_en) begin
            r_entry_count <= i_cfg_wr_data;
        end
    end

    // clamp the count to the table size
    assign count_sat = (32'(r_entry_count) > 32'(TABLE_DEPTH))
                       ? CW'(TABLE_DEPTH) : CW'(r_entry_count);

    stbs_table_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    stbs_search_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_index     (s_axis_tdata[stbs_pkg::INDEX_W-1:0]),
        .i_value     (s_axis_tdata[stbs_pkg::INDEX_W +: stbs_pkg::VALUE_W]),
        .i_count     (count_sat),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_valid     (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (result)
    );

    // pack the result item: position in tdata, zero padded to whole bytes
    assign m_axis_tdata = stbs_pkg::M_TDATA_W'(result.position);
    assign m_axis_tuser = result.found;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sorted_table_binary_search: table writes and
// searches on the input stream, results checked against a local predictor.
// Depends on stbs_pkg and the sorted_table_binary_search RTL.

module tb_top;

    localparam int TABLE_DEPTH = 1024;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT = 500000;

    localparam logic signed [stbs_pkg::VALUE_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [stbs_pkg::VALUE_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

    // Predictor state and the queue of search results still owed by the block.
    class search_checker;
        logic signed [stbs_pkg::VALUE_W-1:0] entries [TABLE_DEPTH];
        logic [stbs_pkg::COUNT_W-1:0]        entry_count;
        stbs_pkg::t_result                   pending_lookups [$];
        int                                  errors;

        function new();
            entry_count = '0;
            errors = 0;
        endfunction

        // Walk the same probe order as the block: floor midpoint, stop on equal.
        function stbs_pkg::t_result predict_lookup(
                logic signed [stbs_pkg::VALUE_W-1:0] target);
            stbs_pkg::t_result res;
            int lo;
            int hi;
            int mid;
            res = '0;
            lo = 0;
            hi = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH - 1 : int'(entry_count) - 1;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (entries[mid] == target) begin
                    res.found = 1'b1;
                    res.position = mid[stbs_pkg::POS_W-1:0];
                    break;
                end else if (entries[mid] < target) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end
            return res;
        endfunction

        function void note_item(logic cmd, logic [stbs_pkg::INDEX_W-1:0] idx,
                                logic signed [stbs_pkg::VALUE_W-1:0] val);
            if (cmd == stbs_pkg::CMD_WRITE) begin
                entries[idx] = val;
            end else begin
                pending_lookups.push_back(predict_lookup(val));
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("mismatch at %0t: %0s", $realtime, what);
        endtask

        task check_result(logic found, logic [stbs_pkg::POS_W-1:0] position);
            stbs_pkg::t_result want;
            if (pending_lookups.size() == 0) begin
                report_mismatch("result item with no search outstanding");
            end else begin
                want = pending_lookups.pop_front();
                if (found !== want.found) begin
                    report_mismatch($sformatf("found %b, predicted %b", found, want.found));
                end
                if (position !== want.position) begin
                    report_mismatch($sformatf("position %0d, predicted %0d",
                                              position, want.position));
                end
            end
        endtask
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_wr_en;
    logic [stbs_pkg::COUNT_W-1:0]     i_cfg_wr_data;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [stbs_pkg::S_TDATA_W-1:0]   s_axis_tdata;    // index[9:0], value[41:10], zero pad
    logic                             s_axis_tuser;    // cmd
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [stbs_pkg::M_TDATA_W-1:0]   m_axis_tdata;    // position[9:0], zero pad
    logic                             m_axis_tuser;    // found

    search_checker sb;
    bit            tx_idle_on;
    bit            rx_idle_on;
    int            rx_hold;
    int            cycle_count;

    sorted_table_binary_search #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs or drops a result.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: check every item taken, values sampled as they stood
    // before the edge. Then pick the next ready level, stalling in bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tuser, m_axis_tdata[stbs_pkg::POS_W-1:0]);
        end
        if (!rx_idle_on) begin
            m_axis_tready <= 1'b1;
            rx_hold = 0;
        end else if (rx_hold != 0) begin
            rx_hold--;
        end else if ($urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            rx_hold = $urandom_range(0, 18);
        end else begin
            m_axis_tready <= 1'b1;
            rx_hold = $urandom_range(0, 30);
        end
    end

    // Offer one item and hold it until the block takes it. Leave tvalid high
    // afterwards so back-to-back items are offered without tvalid dropping.
    task automatic push_item(logic cmd, logic [stbs_pkg::INDEX_W-1:0] idx,
                             logic signed [stbs_pkg::VALUE_W-1:0] val);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {{(stbs_pkg::S_TDATA_W - stbs_pkg::INDEX_W
                           - stbs_pkg::VALUE_W){1'b0}}, val, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(cmd, idx, val);
    endtask

    task automatic search_for(logic signed [stbs_pkg::VALUE_W-1:0] target);
        push_item(stbs_pkg::CMD_SEARCH, stbs_pkg::INDEX_W'($urandom), target);
    endtask

    // Drop tvalid, wait for every owed result, then let a trailing write finish.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_lookups.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_entry_count(logic [stbs_pkg::COUNT_W-1:0] count);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= count;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.entry_count = count;
    endtask

    // Load the whole table in ascending order with runs of duplicates,
    // spanning the full signed range.
    task automatic fill_sorted_table();
        longint acc;
        int     pick;
        acc = MOST_NEG;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            pick = $urandom_range(0, 9);
            if (i == 0) begin
                acc = MOST_NEG;
            end else if (i == TABLE_DEPTH - 1) begin
                acc = MOST_POS;
            end else if (pick == 2) begin
                acc += 1;
            end else if (pick > 2) begin
                acc += $urandom_range(0, 1 << 23);
            end
            if (acc > MOST_POS) begin
                acc = MOST_POS;
            end
            push_item(stbs_pkg::CMD_WRITE, stbs_pkg::INDEX_W'(i),
                      acc[stbs_pkg::VALUE_W-1:0]);
        end
    endtask

    // Mostly searches aimed at stored entries or just beside them, some
    // writes that keep the order, and a little noise that breaks it.
    task automatic lookup_traffic(int n_items);
        int                                  span;
        int                                  roll;
        int                                  slot;
        longint                              lo;
        longint                              hi;
        longint                              draw;
        logic signed [stbs_pkg::VALUE_W-1:0] pick_val;
        span = (sb.entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(sb.entry_count);
        if (span == 0) begin
            span = TABLE_DEPTH;
        end
        for (int n = 0; n < n_items; n++) begin
            roll = $urandom_range(0, 99);
            slot = $urandom_range(0, span - 1);
            pick_val = sb.entries[slot];
            if (roll < 55) begin
                search_for(pick_val);
            end else if (roll < 75) begin
                search_for(($urandom_range(0, 1) != 0) ? pick_val + 1 : pick_val - 1);
            end else if (roll < 85) begin
                search_for($urandom);
            end else if (roll < 90) begin
                case ($urandom_range(0, 3))
                    0: search_for(MOST_NEG);
                    1: search_for(MOST_POS);
                    2: search_for(0);
                    default: search_for(-1);
                endcase
            end else if (roll < 97) begin
                slot = $urandom_range(0, TABLE_DEPTH - 1);
                lo = (slot > 0) ? longint'(sb.entries[slot - 1]) : longint'(MOST_NEG);
                hi = (slot < TABLE_DEPTH - 1) ? longint'(sb.entries[slot + 1])
                                             : longint'(MOST_POS);
                if (hi < lo) begin
                    hi = lo;
                end
                draw = {$urandom_range(0, 32'h7FFF_FFFF), $urandom};
                draw = lo + draw % (hi - lo + 1);
                push_item(stbs_pkg::CMD_WRITE, stbs_pkg::INDEX_W'(slot),
                          draw[stbs_pkg::VALUE_W-1:0]);
            end else begin
                push_item(stbs_pkg::CMD_WRITE, stbs_pkg::INDEX_W'($urandom), $urandom);
            end
        end
    endtask

    initial begin
        logic [stbs_pkg::COUNT_W-1:0] phase_counts [10];

        sb = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = stbs_pkg::CMD_WRITE;
        m_axis_tready = 1'b0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        rx_hold = 0;
        cycle_count = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // An empty range reads nothing and must miss whatever the target.
        set_entry_count(11'd0);
        search_for(MOST_NEG);
        search_for(MOST_POS);
        search_for(0);

        // Small sorted table with both value extremes, and the top index.
        push_item(stbs_pkg::CMD_WRITE, 10'd0, MOST_NEG);
        push_item(stbs_pkg::CMD_WRITE, 10'd1, -5);
        push_item(stbs_pkg::CMD_WRITE, 10'd2, -1);
        push_item(stbs_pkg::CMD_WRITE, 10'd3, 0);
        push_item(stbs_pkg::CMD_WRITE, 10'd4, 1);
        push_item(stbs_pkg::CMD_WRITE, 10'd5, 100);
        push_item(stbs_pkg::CMD_WRITE, 10'd6, MOST_POS - 1);
        push_item(stbs_pkg::CMD_WRITE, 10'd7, MOST_POS);
        push_item(stbs_pkg::CMD_WRITE, 10'h3FF, 12345);
        settle();

        set_entry_count(11'd8);
        search_for(MOST_NEG);
        search_for(MOST_POS);
        search_for(0);
        search_for(1);
        search_for(-3);
        search_for(50);
        search_for(MOST_POS - 1);
        search_for(-1);
        // Break the order in the middle: the probe sequence decides the answer.
        push_item(stbs_pkg::CMD_WRITE, 10'd4, -100);
        search_for(-100);
        search_for(100);
        settle();

        set_entry_count(11'd1);
        search_for(MOST_NEG);
        search_for(5);

        fill_sorted_table();
        settle();

        // Full table, saturated counts, tiny ranges and a few odd sizes.
        phase_counts = '{11'd1024, 11'd2047, 11'd1, 11'd2, 11'd3, 11'd1025,
                         11'd0, 11'd700, 11'd0, 11'd1024};
        phase_counts[6] = stbs_pkg::COUNT_W'($urandom_range(4, 1023));
        phase_counts[8] = stbs_pkg::COUNT_W'($urandom_range(4, 1023));
        foreach (phase_counts[p]) begin
            tx_idle_on = (p < 9) && ($urandom_range(0, 4) != 0);
            rx_idle_on = (p < 9) && ($urandom_range(0, 4) != 0);
            set_entry_count(phase_counts[p]);
            lookup_traffic(75);
            settle();
        end

        if (sb.errors == 0 && sb.pending_lookups.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
